@@ hw/rtl/cartridge_rom_descrambler_top_defines.svh @@
// assertion macros shared by the descrambler checker
`ifndef CARTRIDGE_ROM_DESCRAMBLER_TOP_DEFINES_SVH
`define CARTRIDGE_ROM_DESCRAMBLER_TOP_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define CRD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("descrambler check failed");

// condition holds on every clock edge outside reset
`define CRD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("descrambler invariant failed");

`endif

@@ hw/rtl/crd_pkg.sv @@
// types, tables and bit functions of the cartridge rom descrambler
`timescale 1ns / 1ps

package crd_pkg;

   localparam int OP_WIDTH    = 3;
   localparam int INDEX_WIDTH = 24;
   localparam int DATA_WIDTH  = 32;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_SPR_GATHER  = 3'd0,
      OP_SPR_SCATTER = 3'd1,
      OP_FIX_BYTE    = 3'd2,
      OP_FIX_GATHER  = 3'd3,
      OP_BIOS_WORD   = 3'd4
   } op_type;

   // one pipeline stage's control
   typedef struct packed {
      logic                valid;
      logic [OP_WIDTH-1:0] op;
   } crd_ctl_type;

   localparam logic [31:0] SPR_DATA_KEY   = 32'he9c42134;
   localparam logic [23:0] SPR_GATHER_KEY = 24'h0c8923;
   localparam logic [7:0]  BYTE_KEY       = 8'hd2;

   // permutation tables list, from the msb of the result down, the source bit
   localparam logic [4:0] SPR_DATA_PERM [32] = '{
      5'd9,  5'd13, 5'd19, 5'd0,  5'd23, 5'd15, 5'd3,  5'd5,
      5'd4,  5'd12, 5'd17, 5'd30, 5'd18, 5'd21, 5'd11, 5'd6,
      5'd27, 5'd10, 5'd26, 5'd28, 5'd20, 5'd2,  5'd14, 5'd29,
      5'd24, 5'd8,  5'd1,  5'd16, 5'd25, 5'd31, 5'd7,  5'd22
   };
   localparam logic [4:0] SPR_GATHER_PERM [24] = '{
      5'd23, 5'd22, 5'd21, 5'd4,  5'd11, 5'd14, 5'd8,  5'd12,
      5'd16, 5'd0,  5'd10, 5'd19, 5'd3,  5'd6,  5'd2,  5'd7,
      5'd13, 5'd1,  5'd17, 5'd9,  5'd20, 5'd15, 5'd18, 5'd5
   };
   localparam logic [4:0] SPR_SCATTER_PERM [24] = '{
      5'd23, 5'd21, 5'd10, 5'd20, 5'd19, 5'd22, 5'd18, 5'd17,
      5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd9,  5'd8,
      5'd7,  5'd6,  5'd5,  5'd4,  5'd3,  5'd2,  5'd1,  5'd0
   };
   localparam logic [2:0] BYTE_PERM [8] = '{
      3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd1, 3'd6, 3'd3
   };
   localparam logic [3:0] BIOS_TABLE [64] = '{
      4'h4, 4'ha, 4'h4, 4'ha, 4'h4, 4'ha, 4'h4, 4'ha,
      4'ha, 4'h4, 4'ha, 4'h4, 4'ha, 4'h4, 4'ha, 4'h4,
      4'h9, 4'h7, 4'h9, 4'h7, 4'h9, 4'h7, 4'h9, 4'h7,
      4'h9, 4'h9, 4'h4, 4'h4, 4'h9, 4'h9, 4'h4, 4'h4,
      4'hb, 4'hd, 4'hb, 4'hd, 4'h3, 4'h5, 4'h3, 4'h5,
      4'he, 4'he, 4'h3, 4'h3, 4'he, 4'he, 4'h3, 4'h3,
      4'h3, 4'h5, 4'hb, 4'hd, 4'h3, 4'h5, 4'hb, 4'hd,
      4'h4, 4'h0, 4'h4, 4'h0, 4'he, 4'ha, 4'he, 4'ha
   };

   function automatic logic [31:0] perm_spr_data(input logic [31:0] v);
      logic [31:0] r;
      r = '0;
      for (int k = 0; k < 32; k++) begin
         r[5'(31 - k)] = v[SPR_DATA_PERM[5'(k)]];
      end
      return r;
   endfunction

   function automatic logic [23:0] perm_spr_gather(input logic [23:0] v);
      logic [23:0] r;
      r = '0;
      for (int k = 0; k < 24; k++) begin
         r[5'(23 - k)] = v[SPR_GATHER_PERM[5'(k)]];
      end
      return r;
   endfunction

   function automatic logic [23:0] perm_spr_scatter(input logic [23:0] v);
      logic [23:0] r;
      r = '0;
      for (int k = 0; k < 24; k++) begin
         r[5'(23 - k)] = v[SPR_SCATTER_PERM[5'(k)]];
      end
      return r;
   endfunction

   function automatic logic [7:0] perm_byte(input logic [7:0] v);
      logic [7:0] r;
      r = '0;
      for (int k = 0; k < 8; k++) begin
         r[3'(7 - k)] = v[BYTE_PERM[3'(k)]];
      end
      return r;
   endfunction

   // address flips of the bios scheme (bit 5 always, the rest index-dependent), table excluded
   function automatic logic [23:0] bios_addr_mask(input logic [23:0] idx);
      logic [23:0] m;
      m     = 24'h000020;
      m[4]  = idx[5];
      m[6]  = ~idx[4];
      m[7]  = ~idx[2];
      m[8]  = idx[9];
      m[10] = ~idx[13];
      m[12] = ~idx[16];
      m[15] = idx[13];
      return m;
   endfunction

endpackage

@@ hw/rtl/cartridge_rom_descrambler_top.sv @@
// top level of the cartridge rom descrambler
`timescale 1ns / 1ps

// Cartridge ROM descrambler. Each transfer carries an operation code, an item
// index and the raw data fetched for it; the block returns the mapped address
// and the plain data for five board schemes (sprite gather, sprite scatter,
// fixed byte, fixed gather, bios word). Unused operation codes return zeros.
// Throughput is one transfer per clock: busy is low except while reset is
// held, so start may be high on every cycle. The datapath is a fixed
// three-stage pipeline (key xor, bit permutation, final key or table xor);
// rsp_strobe is driven by the third stage's valid register and is high for
// one cycle per item. The receiver cannot stall the block; results must be
// taken in the cycle they are shown. No state is kept between items.

module cartridge_rom_descrambler_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [crd_pkg::OP_WIDTH-1:0]    req_operation,
   input  logic [crd_pkg::INDEX_WIDTH-1:0] req_index,
   input  logic [crd_pkg::DATA_WIDTH-1:0]  req_raw_data,
   output logic                            rsp_strobe,
   output logic [crd_pkg::INDEX_WIDTH-1:0] rsp_mapped_address,
   output logic [crd_pkg::DATA_WIDTH-1:0]  rsp_plain_data
);
   import crd_pkg::*;

   crd_ctl_type s1_ctl_ff, s1_ctl_in;
   crd_ctl_type s2_ctl_ff;
   logic        s3_valid_ff;
   logic        accept;

   // nothing can hold the pipe, so only reset blocks a transfer
   assign busy   = reset;
   assign accept = start & ~busy;

   assign s1_ctl_in = '{valid: accept, op: req_operation};

   // valid bits per stage, cleared by reset; opcode travels alongside the
   // data and needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_ctl_ff.valid <= 1'b0;
         s3_valid_ff     <= 1'b0;
      end else begin
         s1_ctl_ff.valid <= s1_ctl_in.valid;
         s2_ctl_ff.valid <= s1_ctl_ff.valid;
         s3_valid_ff     <= s2_ctl_ff.valid;
      end
      s1_ctl_ff.op <= s1_ctl_in.op;
      s2_ctl_ff.op <= s1_ctl_ff.op;
   end

   // address mapping: permutations, bit shuffles, gather key xor, bios flips and table
   crd_addr_path u_addr_path (
      .clock     (clock),
      .req_index (req_index),
      .s1_ctl    (s1_ctl_ff),
      .s2_ctl    (s2_ctl_ff),
      .addr_out  (rsp_mapped_address)
   );

   // data descrambling: key xor, bit permutation, bios bit flips
   crd_data_path u_data_path (
      .clock         (clock),
      .req_operation (req_operation),
      .req_raw_data  (req_raw_data),
      .s1_ctl        (s1_ctl_ff),
      .s2_ctl        (s2_ctl_ff),
      .data_out      (rsp_plain_data)
   );

   assign rsp_strobe = s3_valid_ff;

endmodule

@@ hw/rtl/crd_addr_path.sv @@
// three-stage address mapping path of the descrambler
`timescale 1ns / 1ps

module crd_addr_path (
   input  logic                             clock,
   input  logic [crd_pkg::INDEX_WIDTH-1:0]  req_index,
   input  crd_pkg::crd_ctl_type             s1_ctl,
   input  crd_pkg::crd_ctl_type             s2_ctl,
   output logic [crd_pkg::INDEX_WIDTH-1:0]  addr_out
);
   import crd_pkg::*;

   logic [INDEX_WIDTH-1:0] idx1_ff;
   logic [INDEX_WIDTH-1:0] addr2_ff, addr2_in;
   logic [5:0]             tix2_ff;
   logic [INDEX_WIDTH-1:0] addr3_ff, addr3_in;
   logic [INDEX_WIDTH-1:0] scat_perm;
   logic [INDEX_WIDTH-1:0] gath_perm;

   // scatter works on the byte address index*4, low 23 bits permuted
   assign scat_perm = perm_spr_scatter({1'b0, idx1_ff[20:0], 2'b00});
   assign gath_perm = perm_spr_gather({3'b000, idx1_ff[20:0]});

   always_comb begin
      case (s1_ctl.op)
         OP_SPR_GATHER:  addr2_in = {idx1_ff[23:21], gath_perm[20:0]};
         OP_SPR_SCATTER: addr2_in = {idx1_ff[23:21], scat_perm[22:2]};
         OP_FIX_BYTE:    addr2_in = idx1_ff;
         OP_FIX_GATHER:  addr2_in = {idx1_ff[23:5], idx1_ff[2:0], ~idx1_ff[3], idx1_ff[4]};
         OP_BIOS_WORD:   addr2_in = idx1_ff ^ bios_addr_mask(idx1_ff);
         default:        addr2_in = '0;
      endcase
   end

   always_comb begin
      case (s2_ctl.op)
         OP_SPR_GATHER: addr3_in = addr2_ff ^ SPR_GATHER_KEY;
         OP_BIOS_WORD:  addr3_in = addr2_ff ^ {20'h00000, BIOS_TABLE[tix2_ff]};
         default:       addr3_in = addr2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= req_index;
      addr2_ff <= addr2_in;
      tix2_ff  <= {idx1_ff[6:4], idx1_ff[2:0]};
      addr3_ff <= addr3_in;
   end

   assign addr_out = addr3_ff;

endmodule

@@ hw/rtl/crd_data_path.sv @@
// three-stage data descrambling path
`timescale 1ns / 1ps

module crd_data_path (
   input  logic                             clock,
   input  logic [crd_pkg::OP_WIDTH-1:0]     req_operation,
   input  logic [crd_pkg::DATA_WIDTH-1:0]   req_raw_data,
   input  crd_pkg::crd_ctl_type             s1_ctl,
   input  crd_pkg::crd_ctl_type             s2_ctl,
   output logic [crd_pkg::DATA_WIDTH-1:0]   data_out
);
   import crd_pkg::*;

   logic [DATA_WIDTH-1:0] data1_ff, data1_in;
   logic [DATA_WIDTH-1:0] data2_ff, data2_in;
   logic [DATA_WIDTH-1:0] data3_ff, data3_in;

   // key xor for sprite and fixed modes (bios word passes raw), high bits outside the mode's width dropped
   always_comb begin
      case (req_operation)
         OP_SPR_GATHER, OP_SPR_SCATTER: data1_in = req_raw_data ^ SPR_DATA_KEY;
         OP_FIX_BYTE, OP_FIX_GATHER:    data1_in = {24'h000000, req_raw_data[7:0] ^ BYTE_KEY};
         OP_BIOS_WORD:                  data1_in = {16'h0000, req_raw_data[15:0]};
         default:                       data1_in = '0;
      endcase
   end

   always_comb begin
      case (s1_ctl.op)
         OP_SPR_GATHER, OP_SPR_SCATTER: data2_in = perm_spr_data(data1_ff);
         OP_FIX_BYTE, OP_FIX_GATHER:    data2_in = {24'h000000, perm_byte(data1_ff[7:0])};
         OP_BIOS_WORD:                  data2_in = data1_ff;
         default:                       data2_in = '0;
      endcase
   end

   // bios word: bits 0, 1, 3 flip with bits 2, 4, 5
   always_comb begin
      data3_in = data2_ff;
      case (s2_ctl.op)
         OP_BIOS_WORD: begin
            data3_in[0] = data2_ff[0] ^ data2_ff[2];
            data3_in[1] = data2_ff[1] ^ data2_ff[4];
            data3_in[3] = data2_ff[3] ^ data2_ff[5];
         end
         default: data3_in = data2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data1_ff <= data1_in;
      data2_ff <= data2_in;
      data3_ff <= data3_in;
   end

   assign data_out = data3_ff;

endmodule

@@ hw/rtl/crd_checker.sv @@
// port-level checks of the descrambler, bound to the top level
`timescale 1ns / 1ps
`include "cartridge_rom_descrambler_top_defines.svh"

module crd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [crd_pkg::OP_WIDTH-1:0]    req_operation,
   input logic [crd_pkg::INDEX_WIDTH-1:0] req_index,
   input logic [crd_pkg::DATA_WIDTH-1:0]  req_raw_data,
   input logic                            rsp_strobe,
   input logic [crd_pkg::INDEX_WIDTH-1:0] rsp_mapped_address,
   input logic [crd_pkg::DATA_WIDTH-1:0]  rsp_plain_data
);
   import crd_pkg::*;

   logic acc;
   logic unused_op;
   logic byte_op;

   assign acc       = start & ~busy;
   assign unused_op = (req_operation != OP_SPR_GATHER) && (req_operation != OP_SPR_SCATTER)
                      && (req_operation != OP_FIX_BYTE) && (req_operation != OP_FIX_GATHER)
                      && (req_operation != OP_BIOS_WORD);
   assign byte_op   = (req_operation == OP_FIX_BYTE) || (req_operation == OP_FIX_GATHER);

   // every result comes from an accepted transfer
   `CRD_ASSERT_IMPLY(a_strobe_has_source, clock, reset, rsp_strobe, $past(acc, 3))

   // unused codes give all-zero results
   `CRD_ASSERT_IMPLY(a_unused_zero, clock, reset, rsp_strobe && $past(acc && unused_op, 3), (rsp_mapped_address == '0) && (rsp_plain_data == '0))

   // fixed byte keeps its index as address
   `CRD_ASSERT_IMPLY(a_fix_byte_addr, clock, reset, rsp_strobe && $past(acc && (req_operation == OP_FIX_BYTE), 3), rsp_mapped_address == $past(req_index, 3))

   // byte modes never produce bits above the byte
   `CRD_ASSERT_IMPLY(a_byte_width, clock, reset, rsp_strobe && $past(acc && byte_op, 3), rsp_plain_data[31:8] == '0)

endmodule

bind cartridge_rom_descrambler_top crd_checker u_crd_checker (.*);
